// ===== hw/rtl/evp_pkg.sv =====
// Shared types, constants and helpers for the encoder velocity PID block.
package evp_pkg;

  localparam int INTEGRAL_WIDTH_DEF = 40;
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] REG_GAIN_P = 8'd0;
  localparam logic [7:0] REG_GAIN_I = 8'd1;
  localparam logic [7:0] REG_GAIN_D = 8'd2;
  localparam logic [7:0] REG_CPR    = 8'd3;

  localparam logic [15:0] GAIN_P_RST = 16'd1280;
  localparam logic [15:0] GAIN_I_RST = 16'd26;
  localparam logic [15:0] GAIN_D_RST = 16'd51;
  localparam logic [15:0] CPR_RST    = 16'd517;

  localparam logic [25:0] USEC_PER_MIN = 26'd60000000;
  localparam logic signed [16:0] FILT_A = 17'sd27984;
  localparam logic signed [16:0] FILT_B = 17'sd2386;
  localparam logic [40:0] TERM_LIM = 41'h100_0000_0000;
  localparam logic [7:0] PWM_MAX = 8'd255;

  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_REV  = 2'd2;

  typedef struct packed {
    logic [15:0] gain_p;
    logic [15:0] gain_i;
    logic [15:0] gain_d;
    logic [15:0] cpr;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] dc;
    logic [31:0]        dt;
    logic signed [23:0] target;
  } upd_t;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_CHECK, S_DIV, S_RAW, S_FILT_A, S_FILT_B, S_FILT_C,
    S_ERR, S_SUM, S_TP, S_TI, S_TD, S_OUT
  } back_state_t;

  // gain * magnitude, saturated at TERM_LIM
  function automatic logic [40:0] sat_mul(input logic [40:0] mag, input logic [15:0] gain);
    logic [56:0] prod;
    prod = 57'(mag) * 57'(gain);
    return (prod > 57'(TERM_LIM)) ? TERM_LIM : 41'(prod);
  endfunction

endpackage

// ===== hw/rtl/encoder_velocity_pid.sv =====
// Encoder velocity PID controller: top level.
// Usage:
//   Input channel (in_valid / in_stall) carries action, tick_up, target_speed
//   and time_now_us. A tick (action 0) moves the encoder count and yields no
//   result; it is absorbed in the cycle it is accepted. An update (action 1)
//   snapshots count and time deltas into a two-entry queue and yields exactly
//   one result on the output channel (out_valid / out_stall): pwm_duty,
//   drive_dir and filtered_speed.
//   Config channel (cfg_valid / cfg_ready, always ready) writes gains and
//   counts per revolution by index; write only while the block is idle.
//   The 23-step restoring divider for the raw speed is skipped when the time
//   delta is zero or the speed saturates. Updates are processed one at a
//   time: the back end takes a new update only after the last result has
//   been loaded into the output register. Ticks enter every cycle while the
//   queue has room.
//   in_stall rises when the queue is full. While out_stall is high the held
//   result stays on the ports and the back end waits with the next one.
//   Synchronous reset clears counts, timestamps, filter and PID history and
//   loads the default gains.
module encoder_velocity_pid #(
  parameter int INTEGRAL_WIDTH = evp_pkg::INTEGRAL_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               action,
  input  logic               tick_up,
  input  logic signed [23:0] target_speed,
  input  logic [31:0]        time_now_us,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         pwm_duty,
  output logic [1:0]         drive_dir,
  output logic signed [23:0] filtered_speed,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import evp_pkg::*;

  cfg_t cfg;
  upd_t push_data;
  upd_t head;
  logic push;
  logic pop;
  logic q_full;
  logic q_not_empty;

  evp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .tick_up      (tick_up),
    .target_speed (target_speed),
    .time_now_us  (time_now_us),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .q_full       (q_full),
    .push         (push),
    .push_data    (push_data),
    .cfg          (cfg)
  );

  evp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head)
  );

  evp_back #(
    .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .q_not_empty    (q_not_empty),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .pwm_duty       (pwm_duty),
    .drive_dir      (drive_dir),
    .filtered_speed (filtered_speed)
  );

endmodule

// ===== hw/rtl/evp_front.sv =====
// Front end: input channel, encoder count, update snapshots and config registers.
module evp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                action,
  input  logic                tick_up,
  input  logic signed [23:0]  target_speed,
  input  logic [31:0]         time_now_us,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                q_full,
  output logic                push,
  output evp_pkg::upd_t       push_data,
  output evp_pkg::cfg_t       cfg
);
  import evp_pkg::*;

  logic [31:0] encoder_count;
  logic [31:0] count_at_last;
  logic [31:0] time_at_last;
  logic        accept;

  assign in_stall  = q_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !q_full;
  assign push      = accept && action;

  assign push_data.dc     = signed'(encoder_count - count_at_last);
  assign push_data.dt     = time_now_us - time_at_last;
  assign push_data.target = target_speed;

  always_ff @(posedge clk) begin
    if (rst) begin
      encoder_count <= '0;
      count_at_last <= '0;
      time_at_last  <= '0;
    end else if (accept) begin
      if (!action) begin
        encoder_count <= tick_up ? encoder_count + 32'd1 : encoder_count - 32'd1;
      end else begin
        count_at_last <= encoder_count;
        time_at_last  <= time_now_us;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p <= GAIN_P_RST;
      cfg.gain_i <= GAIN_I_RST;
      cfg.gain_d <= GAIN_D_RST;
      cfg.cpr    <= CPR_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GAIN_P: if (cfg_data != '0) cfg.gain_p <= cfg_data;
        REG_GAIN_I: cfg.gain_i <= cfg_data;
        REG_GAIN_D: cfg.gain_d <= cfg_data;
        REG_CPR:    if (cfg_data != '0) cfg.cpr <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/evp_queue.sv =====
// Short FIFO of pending control updates between front and back.
module evp_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  evp_pkg::upd_t push_data,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output evp_pkg::upd_t head
);
  import evp_pkg::*;

  upd_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QDEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop)      count <= count + QCNT_W'(1);
      else if (pop && !push) count <= count - QCNT_W'(1);
    end
  end

endmodule

// ===== hw/rtl/evp_back.sv =====
// Back end: raw speed divider, IIR filter, PID terms and result register.
module evp_back #(
  parameter int INTEGRAL_WIDTH = evp_pkg::INTEGRAL_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  evp_pkg::cfg_t      cfg,
  input  logic               q_not_empty,
  input  evp_pkg::upd_t      head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         pwm_duty,
  output logic [1:0]         drive_dir,
  output logic signed [23:0] filtered_speed
);
  import evp_pkg::*;

  localparam int IW = INTEGRAL_WIDTH;
  localparam int VW = (IW + 1 > 41) ? IW + 1 : 41;
  localparam logic signed [IW:0] SUM_MAX = (IW + 1)'((65'(1) << (IW - 1)) - 65'(1));
  localparam logic signed [IW:0] SUM_MIN = -SUM_MAX - (IW + 1)'(1);

  back_state_t state, state_next;

  logic               dc_neg;
  logic [31:0]        dc_mag;
  logic [31:0]        dt;
  logic signed [23:0] target;
  logic [47:0]        d;
  logic [57:0]        n;
  logic [47:0]        rem;
  logic [22:0]        nlow;
  logic [22:0]        q;
  logic [4:0]         cnt;
  logic signed [23:0] raw;
  logic signed [23:0] raw_prev;
  logic signed [23:0] filt_prev;
  logic signed [41:0] acc;
  logic signed [24:0] e;
  logic signed [24:0] e_prev;
  logic signed [IW-1:0] esum;
  logic signed [43:0] u;
  logic               can_load;

  // divider step
  logic [48:0] div_t;
  logic        div_ge;
  // filter output
  logic signed [41:0] acc_sh;
  logic signed [23:0] filt_v;
  // integral update
  logic signed [IW:0] sum_w;
  logic signed [IW-1:0] sum_v;
  // PID term
  logic signed [VW-1:0] op;
  logic [VW-1:0]        omag;
  logic                 op_neg;
  logic [40:0]          mclamp;
  logic [40:0]          pmag;
  logic [15:0]          gsel;
  logic signed [43:0]   pt;
  logic signed [43:0]   term;
  // output
  logic [43:0] umag;
  logic [27:0] um;

  assign can_load = !out_valid || !out_stall;
  assign pop      = (state == S_IDLE) && q_not_empty;

  always_comb begin
    div_t  = {rem, nlow[22]};
    div_ge = (div_t >= {1'b0, d});

    acc_sh = acc >>> 15;
    if (acc_sh > 42'sd8388607)       filt_v = 24'sd8388607;
    else if (acc_sh < -42'sd8388608) filt_v = -24'sd8388608;
    else                             filt_v = 24'(acc_sh);

    sum_w = (IW + 1)'(esum) + (IW + 1)'(e);
    if (sum_w > SUM_MAX)      sum_v = IW'(SUM_MAX);
    else if (sum_w < SUM_MIN) sum_v = IW'(SUM_MIN);
    else                      sum_v = IW'(sum_w);

    case (state)
      S_TI: begin
        op   = VW'(esum);
        gsel = cfg.gain_i;
      end
      S_TD: begin
        op   = VW'(e) - VW'(e_prev);
        gsel = cfg.gain_d;
      end
      default: begin
        op   = VW'(e);
        gsel = cfg.gain_p;
      end
    endcase
    op_neg = op[VW-1];
    omag   = op_neg ? unsigned'(-op) : unsigned'(op);
    mclamp = (omag > VW'(TERM_LIM)) ? TERM_LIM : 41'(omag);
    pmag   = sat_mul(mclamp, gsel);
    pt     = signed'(44'(pmag));
    term   = op_neg ? -pt : pt;

    umag = u[43] ? unsigned'(-u) : unsigned'(u);
    um   = umag[43:16];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (q_not_empty) state_next = S_PREP;
      S_PREP:   state_next = S_CHECK;
      S_CHECK: begin
        if (dt == '0 || 64'(n) >= (64'(d) << 15)) state_next = S_FILT_A;
        else                                      state_next = S_DIV;
      end
      S_DIV:    if (cnt == 5'd22) state_next = S_RAW;
      S_RAW:    state_next = S_FILT_A;
      S_FILT_A: state_next = S_FILT_B;
      S_FILT_B: state_next = S_FILT_C;
      S_FILT_C: state_next = S_ERR;
      S_ERR:    state_next = S_SUM;
      S_SUM:    state_next = S_TP;
      S_TP:     state_next = S_TI;
      S_TI:     state_next = S_TD;
      S_TD:     state_next = S_OUT;
      S_OUT:    if (can_load) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_prev  <= '0;
      filt_prev <= '0;
      e_prev    <= '0;
      esum      <= '0;
      out_valid <= 1'b0;
    end else begin
      // drop the accepted result unless a new one is loaded in this cycle
      if (out_valid && !out_stall && state != S_OUT) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_not_empty) begin
            dc_neg <= head.dc[31];
            dc_mag <= head.dc[31] ? unsigned'(-head.dc) : unsigned'(head.dc);
            dt     <= head.dt;
            target <= head.target;
          end
        end
        S_PREP: begin
          d <= 48'(dt) * 48'(cfg.cpr);
          n <= 58'(dc_mag) * 58'(USEC_PER_MIN);
        end
        S_CHECK: begin
          if (dt == '0) begin
            raw <= '0;
          end else if (64'(n) >= (64'(d) << 15)) begin
            raw <= dc_neg ? -24'sd8388608 : 24'sd8388607;
          end else begin
            rem  <= 48'(n >> 15);
            nlow <= {n[14:0], 8'd0};
            q    <= '0;
            cnt  <= '0;
          end
        end
        S_DIV: begin
          rem  <= div_ge ? 48'(div_t - {1'b0, d}) : 48'(div_t);
          q    <= {q[21:0], div_ge};
          nlow <= {nlow[21:0], 1'b0};
          cnt  <= cnt + 5'd1;
        end
        S_RAW: begin
          raw <= dc_neg ? -signed'({1'b0, q}) : signed'({1'b0, q});
        end
        S_FILT_A: acc <= 42'(filt_prev) * 42'(FILT_A);
        S_FILT_B: acc <= acc + 42'(raw) * 42'(FILT_B);
        S_FILT_C: acc <= acc + 42'(raw_prev) * 42'(FILT_B) + 42'sd16384;
        S_ERR: begin
          filt_prev <= filt_v;
          raw_prev  <= raw;
          e         <= 25'(target) - 25'(filt_v);
        end
        S_SUM: begin
          esum <= sum_v;
          u    <= '0;
        end
        S_TP, S_TI: u <= u + term;
        S_TD: begin
          u      <= u + term;
          e_prev <= e;
        end
        S_OUT: begin
          if (can_load) begin
            out_valid      <= 1'b1;
            pwm_duty       <= (um > 28'(PWM_MAX)) ? PWM_MAX : um[7:0];
            drive_dir      <= (u == '0) ? DIR_STOP : (u[43] ? DIR_REV : DIR_FWD);
            filtered_speed <= filt_prev;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
